FILE: rtl/assert_macros.svh
// assertion helpers, clocked on clk and quiet while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ctfr_pkg.sv
package ctfr_pkg;

	localparam int MAX_MESSAGE = 30;
	localparam int BUF_DEPTH   = MAX_MESSAGE + 1;
	localparam int ADDR_W      = $clog2(BUF_DEPTH);
	localparam int LEN_W       = $clog2(MAX_MESSAGE + 1);
	// frame positions reach 7 * 15 + 6 = 111
	localparam int POS_W       = 7;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

	localparam logic [10:0] ID_LOW    = 11'h7E8;
	localparam logic [10:0] ID_HIGH   = 11'h7EF;
	localparam logic [10:0] FC_OFFSET = 11'h008;

	localparam logic [3:0] TYPE_SF = 4'h0;
	localparam logic [3:0] TYPE_FF = 4'h1;
	localparam logic [3:0] TYPE_CF = 4'h2;

	localparam int FF_HEAD_BYTES = 6;
	localparam logic [2:0] FRAME_BYTES = 3'd7;

	localparam logic [1:0] OP_SF = 2'd0;
	localparam logic [1:0] OP_FF = 2'd1;
	localparam logic [1:0] OP_CF = 2'd2;

	localparam logic KIND_FC  = 1'b0;
	localparam logic KIND_MSG = 1'b1;

	// one queued command from front to back
	typedef struct packed {
		logic [1:0]       op;
		logic [10:0]      id;
		logic [6:0][7:0]  data;   // frame bytes 1..7
		logic [2:0]       cnt;    // bytes to store, or single frame length
		logic [POS_W-1:0] base;   // first buffer position to store
		logic             emit;   // consecutive frame completes the message
		logic [LEN_W-1:0] len;    // message length
	} cmd_t;

endpackage

FILE: rtl/ctfr_front.sv
`include "assert_macros.svh"

module ctfr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [10:0]         can_id,
	input  logic [7:0]          data0,
	input  logic [7:0]          data1,
	input  logic [7:0]          data2,
	input  logic [7:0]          data3,
	input  logic [7:0]          data4,
	input  logic [7:0]          data5,
	input  logic [7:0]          data6,
	input  logic [7:0]          data7,
	input  logic                q_full,
	output logic                push,
	output ctfr_pkg::cmd_t      cmd
);

	logic                         asm_q;
	logic [3:0]                   seq_q;
	logic [ctfr_pkg::LEN_W-1:0]   rem_q;
	logic [ctfr_pkg::LEN_W-1:0]   len_q;

	logic                         accept;
	logic                         id_ok;
	logic [3:0]                   ftype;
	logic [3:0]                   nib;
	logic [11:0]                  ff_len;
	logic                         ff_ok;
	logic [3:0]                   seq_nx;
	logic [2:0]                   cf_n;
	logic [ctfr_pkg::LEN_W-1:0]   rem_nx;
	logic [ctfr_pkg::POS_W-1:0]   nib_w;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign id_ok    = (can_id >= ctfr_pkg::ID_LOW) && (can_id <= ctfr_pkg::ID_HIGH);
	assign ftype    = data0[7:4];
	assign nib      = data0[3:0];
	assign ff_len   = {nib, data1};
	assign ff_ok    = (ff_len >= 12'(ctfr_pkg::FF_HEAD_BYTES))
		&& (ff_len <= 12'(ctfr_pkg::MAX_MESSAGE));
	assign seq_nx   = seq_q + 4'd1;
	assign cf_n     = (rem_q > ctfr_pkg::LEN_W'(ctfr_pkg::FRAME_BYTES))
		? ctfr_pkg::FRAME_BYTES : rem_q[2:0];
	assign rem_nx   = rem_q - ctfr_pkg::LEN_W'(cf_n);
	assign nib_w    = ctfr_pkg::POS_W'(nib);

	always_comb begin
		push      = 1'b0;
		cmd.op    = ctfr_pkg::OP_SF;
		cmd.id    = can_id;
		cmd.data  = {data7, data6, data5, data4, data3, data2, data1};
		cmd.cnt   = (nib > 4'd7) ? 3'd7 : nib[2:0];
		// buffer position of this index is 7 * index
		cmd.base  = (nib_w << 3) - nib_w;
		cmd.emit  = 1'b0;
		cmd.len   = len_q;
		if (accept && id_ok) begin
			unique case (ftype)
				ctfr_pkg::TYPE_SF: begin
					push = 1'b1;
				end
				ctfr_pkg::TYPE_FF: begin
					push      = ff_ok;
					cmd.op    = ctfr_pkg::OP_FF;
					cmd.id    = can_id - ctfr_pkg::FC_OFFSET;
					cmd.cnt   = ctfr_pkg::FRAME_BYTES;
					cmd.base  = '0;
				end
				ctfr_pkg::TYPE_CF: begin
					push      = asm_q && (nib == seq_nx);
					cmd.op    = ctfr_pkg::OP_CF;
					cmd.cnt   = cf_n;
					cmd.emit  = (rem_nx == '0);
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_q <= 1'b0;
			seq_q <= '0;
			rem_q <= '0;
			len_q <= '0;
		end else if (accept && id_ok) begin
			if (ftype == ctfr_pkg::TYPE_FF && ff_ok) begin
				asm_q <= 1'b1;
				seq_q <= '0;
				len_q <= ff_len[ctfr_pkg::LEN_W-1:0];
				rem_q <= ff_len[ctfr_pkg::LEN_W-1:0] - ctfr_pkg::LEN_W'(ctfr_pkg::FF_HEAD_BYTES);
			end else if (ftype == ctfr_pkg::TYPE_CF && asm_q) begin
				seq_q <= seq_nx;
				if (nib != seq_nx) begin
					asm_q <= 1'b0;
				end else begin
					rem_q <= rem_nx;
					if (rem_nx == '0) begin
						asm_q <= 1'b0;
					end
				end
			end
		end
	end

	`ASSERT_IMPLY(a_len_range, asm_q,
		(len_q >= ctfr_pkg::LEN_W'(ctfr_pkg::FF_HEAD_BYTES))
		&& (rem_q <= len_q - ctfr_pkg::LEN_W'(ctfr_pkg::FF_HEAD_BYTES)),
		"reassembly length out of range")
	`ASSERT_NEXT(a_done_clears, push && cmd.op == ctfr_pkg::OP_CF && cmd.emit,
		!asm_q, "completed message left reassembly armed")

endmodule

FILE: rtl/ctfr_fifo.sv
`include "assert_macros.svh"

module ctfr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ctfr_pkg::cmd_t cmd_in,
	output logic           full,
	input  logic           pop,
	output ctfr_pkg::cmd_t cmd_out,
	output logic           empty
);

	ctfr_pkg::cmd_t                 slot_q [ctfr_pkg::FIFO_DEPTH];
	logic [ctfr_pkg::FIFO_AW-1:0]   wr_q;
	logic [ctfr_pkg::FIFO_AW-1:0]   rd_q;
	logic [ctfr_pkg::FIFO_CW-1:0]   cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign full    = (cnt_q == ctfr_pkg::FIFO_CW'(ctfr_pkg::FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign cmd_out = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == ctfr_pkg::FIFO_AW'(ctfr_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == ctfr_pkg::FIFO_AW'(ctfr_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_ALWAYS(a_no_overflow, !(push && full), "command pushed into a full queue")

endmodule

FILE: rtl/ctfr_back.sv
`include "assert_macros.svh"

module ctfr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  ctfr_pkg::cmd_t              cmd_in,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        kind,
	output logic [10:0]                 node_id,
	output logic [7:0]                  msg_byte,
	output logic [ctfr_pkg::LEN_W-1:0]  byte_index,
	output logic                        last
);

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_WRITE = 2'd1;
	localparam logic [1:0] B_READ  = 2'd2;
	localparam logic [1:0] B_EMIT  = 2'd3;

	logic [7:0]                   mem [ctfr_pkg::BUF_DEPTH];
	logic [1:0]                   state_q;
	ctfr_pkg::cmd_t               cmd_q;
	logic [2:0]                   w_q;
	logic [ctfr_pkg::LEN_W-1:0]   k_q;
	logic [7:0]                   rdata_q;
	logic                         out_vld_q;

	logic [ctfr_pkg::POS_W-1:0]   wpos;
	logic                         wr_en;
	logic                         out_free;
	logic                         load;
	logic [7:0]                   e_byte;
	logic                         e_kind;
	logic [ctfr_pkg::LEN_W-1:0]   e_lastk;
	logic                         e_last;
	logic [2:0]                   sf_sel;

	function automatic logic [1:0] after_write(input ctfr_pkg::cmd_t c);
		logic [1:0] nx;
		if (c.op == ctfr_pkg::OP_FF) begin
			nx = B_EMIT;
		end else if (c.emit) begin
			nx = B_READ;
		end else begin
			nx = B_IDLE;
		end
		return nx;
	endfunction

	assign pop       = (state_q == B_IDLE) && !q_empty;
	assign wpos      = cmd_q.base + ctfr_pkg::POS_W'(w_q);
	assign wr_en     = (state_q == B_WRITE) && (wpos < ctfr_pkg::POS_W'(ctfr_pkg::BUF_DEPTH));
	assign out_free  = !out_vld_q || !out_stall;
	assign load      = (state_q == B_EMIT) && out_free;
	assign out_valid = out_vld_q;
	assign sf_sel    = k_q[2:0] - 3'd1;

	always_comb begin
		e_kind  = ctfr_pkg::KIND_MSG;
		e_byte  = rdata_q;
		e_lastk = cmd_q.len;
		unique case (cmd_q.op)
			ctfr_pkg::OP_SF: begin
				// byte 0 of a single frame is its clamped length
				e_byte  = (k_q == '0) ? 8'(cmd_q.cnt) : cmd_q.data[sf_sel];
				e_lastk = ctfr_pkg::LEN_W'(cmd_q.cnt);
			end
			ctfr_pkg::OP_FF: begin
				e_kind  = ctfr_pkg::KIND_FC;
				e_byte  = '0;
				e_lastk = '0;
			end
			ctfr_pkg::OP_CF: begin
				e_byte  = rdata_q;
			end
			default: begin
				e_byte  = rdata_q;
			end
		endcase
		e_last = (k_q == e_lastk);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wpos[ctfr_pkg::ADDR_W-1:0]] <= cmd_q.data[w_q];
		end
		if (state_q == B_READ) begin
			rdata_q <= mem[ctfr_pkg::ADDR_W'(k_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd_in;
		end
		if (load) begin
			kind       <= e_kind;
			node_id    <= cmd_q.id;
			msg_byte   <= e_byte;
			byte_index <= k_q;
			last       <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			w_q       <= '0;
			k_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						w_q <= '0;
						k_q <= '0;
						if (cmd_in.op == ctfr_pkg::OP_SF) begin
							state_q <= B_EMIT;
						end else if (cmd_in.cnt == '0) begin
							state_q <= after_write(cmd_in);
						end else begin
							state_q <= B_WRITE;
						end
					end
				end
				B_WRITE: begin
					w_q <= w_q + 3'd1;
					if (w_q == cmd_q.cnt - 3'd1) begin
						state_q <= after_write(cmd_q);
					end
				end
				B_READ: begin
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (load) begin
						if (e_last) begin
							state_q <= B_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= (cmd_q.op == ctfr_pkg::OP_CF) ? B_READ : B_EMIT;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMPLY(a_no_sf_write, state_q == B_WRITE,
		cmd_q.op != ctfr_pkg::OP_SF, "single frame reached the buffer write phase")
	`ASSERT_IMPLY(a_fc_single, load && e_kind == ctfr_pkg::KIND_FC,
		e_last && k_q == '0, "flow-control request not a lone last result")

endmodule

FILE: rtl/can_transport_frame_reassembler.sv
// Receive-side transport reassembler for 11-bit diagnostic responses on IDs 0x7E8..0x7EF.
// A front end classifies each frame and tracks the sequence, pushing commands into a
// four-entry queue, so frames are taken at one per cycle until the queue fills. The back
// end works one command at a time: a single frame gives its length and data at one result
// per cycle while the output is not stalled; a first frame writes its seven bytes to the
// buffer and then gives one flow-control result addressed to the ID minus 8; a consecutive
// frame writes its stored bytes to the buffer, and the one that completes a message emits
// length + 1 bytes, each read through the buffer's single read port before it is emitted.
// A result register sits at the output, and further results wait while it is not taken.
module can_transport_frame_reassembler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [10:0]                 can_id,
	input  logic [7:0]                  data0,
	input  logic [7:0]                  data1,
	input  logic [7:0]                  data2,
	input  logic [7:0]                  data3,
	input  logic [7:0]                  data4,
	input  logic [7:0]                  data5,
	input  logic [7:0]                  data6,
	input  logic [7:0]                  data7,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        kind,
	output logic [10:0]                 node_id,
	output logic [7:0]                  msg_byte,
	output logic [ctfr_pkg::LEN_W-1:0]  byte_index,
	output logic                        last
);

	ctfr_pkg::cmd_t  f_cmd;
	ctfr_pkg::cmd_t  q_cmd;
	logic            f_push;
	logic            q_full;
	logic            q_empty;
	logic            b_pop;

	ctfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.can_id   (can_id),
		.data0    (data0),
		.data1    (data1),
		.data2    (data2),
		.data3    (data3),
		.data4    (data4),
		.data5    (data5),
		.data6    (data6),
		.data7    (data7),
		.q_full   (q_full),
		.push     (f_push),
		.cmd      (f_cmd)
	);

	ctfr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.cmd_in  (f_cmd),
		.full    (q_full),
		.pop     (b_pop),
		.cmd_out (q_cmd),
		.empty   (q_empty)
	);

	ctfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.cmd_in     (q_cmd),
		.pop        (b_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.node_id    (node_id),
		.msg_byte   (msg_byte),
		.byte_index (byte_index),
		.last       (last)
	);

endmodule

FILE: dv/tb_can_transport_frame_reassembler.sv
module tb_can_transport_frame_reassembler;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] TYPE_FC   = 4'h3;
	localparam int WATCHDOG_LIMIT    = 3000;
	localparam int HOLD_CYCLES       = 400;
	localparam int TAIL_CYCLES       = 200;
	localparam int PRINT_LIMIT       = 40;

	typedef struct packed {
		logic [10:0]     id;
		logic [7:0][7:0] b;   // b[0] is the protocol control byte
	} frame_t;

	typedef struct packed {
		logic                       kind;
		logic [10:0]                node_id;
		logic [7:0]                 msg_byte;
		logic [ctfr_pkg::LEN_W-1:0] byte_index;
		logic                       last;
	} result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [10:0]                can_id;
	logic [7:0]                 data0, data1, data2, data3, data4, data5, data6, data7;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       kind;
	logic [10:0]                node_id;
	logic [7:0]                 msg_byte;
	logic [ctfr_pkg::LEN_W-1:0] byte_index;
	logic                       last;

	can_transport_frame_reassembler u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.can_id     (can_id),
		.data0      (data0),
		.data1      (data1),
		.data2      (data2),
		.data3      (data3),
		.data4      (data4),
		.data5      (data5),
		.data6      (data6),
		.data7      (data7),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.node_id    (node_id),
		.msg_byte   (msg_byte),
		.byte_index (byte_index),
		.last       (last)
	);

	// reassembly shadow state
	logic [7:0]  msg_store [ctfr_pkg::BUF_DEPTH];
	bit          reassembling = 1'b0;
	logic [3:0]  seq_count = '0;
	int          bytes_left = 0;
	int          msg_len = 0;

	result_t     expected_results [$];
	int          frames_sent = 0;
	int          fail_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_token = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < ctfr_pkg::BUF_DEPTH; i++) begin
			msg_store[i] = '0;
		end
	end

	function automatic void push_result(logic k, logic [10:0] id, logic [7:0] value, int idx,
			logic is_last);
		result_t r;
		r.kind = k;
		r.node_id = id;
		r.msg_byte = value;
		r.byte_index = ctfr_pkg::LEN_W'(idx);
		r.last = is_last;
		expected_results.push_back(r);
	endfunction

	function automatic void predict_frame(frame_t f);
		logic [3:0] ftype;
		logic [3:0] nib;
		int len, n, base, total;
		ftype = f.b[0][7:4];
		nib = f.b[0][3:0];
		if (f.id < ctfr_pkg::ID_LOW || f.id > ctfr_pkg::ID_HIGH) begin
			return;
		end
		case (ftype)
			ctfr_pkg::TYPE_SF: begin
				len = (nib > 7) ? 7 : int'(nib);
				push_result(ctfr_pkg::KIND_MSG, f.id, 8'(len), 0, len == 0);
				for (int i = 1; i <= len; i++) begin
					push_result(ctfr_pkg::KIND_MSG, f.id, f.b[i], i, i == len);
				end
			end
			ctfr_pkg::TYPE_FF: begin
				len = {nib, f.b[1]};
				if (len > ctfr_pkg::MAX_MESSAGE || len < ctfr_pkg::FF_HEAD_BYTES) begin
					return;
				end
				for (int i = 0; i < 7; i++) begin
					msg_store[i] = f.b[i + 1];
				end
				msg_len = len;
				bytes_left = len - ctfr_pkg::FF_HEAD_BYTES;
				seq_count = '0;
				reassembling = 1'b1;
				push_result(ctfr_pkg::KIND_FC, f.id - ctfr_pkg::FC_OFFSET, 8'h00, 0, 1'b1);
			end
			ctfr_pkg::TYPE_CF: begin
				if (!reassembling) begin
					return;
				end
				seq_count = seq_count + 4'd1;
				if (nib != seq_count) begin
					reassembling = 1'b0;
					return;
				end
				n = (bytes_left > 7) ? 7 : bytes_left;
				// nothing is stored for index zero
				if (nib != 0) begin
					base = 7 + (int'(nib) - 1) * int'(ctfr_pkg::FRAME_BYTES);
					for (int i = 0; i < n; i++) begin
						if (base + i < ctfr_pkg::BUF_DEPTH) begin
							msg_store[base + i] = f.b[i + 1];
						end
					end
				end
				bytes_left -= n;
				if (bytes_left == 0) begin
					total = (msg_len + 1 > ctfr_pkg::BUF_DEPTH) ? ctfr_pkg::BUF_DEPTH
						: msg_len + 1;
					reassembling = 1'b0;
					for (int i = 0; i < total; i++) begin
						push_result(ctfr_pkg::KIND_MSG, f.id, msg_store[i], i, i + 1 == total);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic [10:0] rand_id();
		return ctfr_pkg::ID_LOW + 11'($urandom_range(0, 7));
	endfunction

	function automatic frame_t rand_payload(logic [10:0] id, logic [7:0] pci);
		frame_t f;
		f.id = id;
		f.b = {$urandom(), $urandom()};
		f.b[0] = pci;
		return f;
	endfunction

	function automatic frame_t first_frame(logic [10:0] id, int len);
		frame_t f;
		f = rand_payload(id, {ctfr_pkg::TYPE_FF, 4'(len >> 8)});
		f.b[1] = 8'(len);
		return f;
	endfunction

	// frames the block has to pass over without touching reassembly
	function automatic frame_t noise_frame();
		frame_t f;
		f = rand_payload(rand_id(), 8'($urandom_range(8'h30, 8'hFF)));
		if ($urandom_range(1) == 1) begin
			f.id = 11'($urandom());
			if (f.id >= ctfr_pkg::ID_LOW && f.id <= ctfr_pkg::ID_HIGH) begin
				f.id ^= 11'h400;
			end
			f.b[0] = 8'($urandom());
		end
		return f;
	endfunction

	task automatic send_frame(input frame_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		can_id <= f.id;
		data0 <= f.b[0];
		data1 <= f.b[1];
		data2 <= f.b[2];
		data3 <= f.b[3];
		data4 <= f.b[4];
		data5 <= f.b[5];
		data6 <= f.b[6];
		data7 <= f.b[7];
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		frames_sent++;
		predict_frame(f);
	endtask

	task automatic send_message(input logic [10:0] id, input int len, input int noise_pct,
			input int break_pct);
		int rem, cfs;
		logic [3:0] seq;
		logic [10:0] cf_id;
		send_frame(first_frame(id, len));
		rem = len - ctfr_pkg::FF_HEAD_BYTES;
		cfs = (rem == 0) ? 1 : (rem + 6) / 7;
		for (int k = 1; k <= cfs; k++) begin
			if ($urandom_range(99) < noise_pct) begin
				send_frame(noise_frame());
			end
			seq = k[3:0];
			// later frames after a bad index are dropped by the block
			if ($urandom_range(99) < break_pct) begin
				seq = seq + 4'($urandom_range(1, 15));
			end
			cf_id = ($urandom_range(3) == 0) ? rand_id() : id;
			send_frame(rand_payload(cf_id, {ctfr_pkg::TYPE_CF, seq}));
		end
	endtask

	task automatic report_mismatch(input string what, input result_t got, input result_t want);
		if (fail_count < PRINT_LIMIT) begin
			$display("mismatch (%s): got kind %0d id %h byte %h index %0d last %0d, %s",
				what, got.kind, got.node_id, got.msg_byte, got.byte_index, got.last,
				$sformatf("expected kind %0d id %h byte %h index %0d last %0d",
					want.kind, want.node_id, want.msg_byte, want.byte_index, want.last));
		end
		fail_count++;
	endtask

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {kind, node_id, msg_byte, byte_index, last};
			if (expected_results.size() == 0) begin
				report_mismatch("nothing expected", got, '0);
			end else begin
				want = expected_results.pop_front();
				if (got.kind !== want.kind || got.node_id !== want.node_id ||
						got.msg_byte !== want.msg_byte || got.byte_index !== want.byte_index ||
						got.last !== want.last) begin
					report_mismatch("wrong field", got, want);
				end
			end
		end
	end

	// receiver: random stall, or a long hold-off when asked
	always @(posedge clk) begin : rx_side
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic test_foreign_ids;
		send_frame(rand_payload(ctfr_pkg::ID_LOW - 11'd1, {ctfr_pkg::TYPE_SF, 4'd3}));
		send_frame(first_frame(ctfr_pkg::ID_HIGH + 11'd1, 10));
		send_frame(rand_payload(11'h7FF, {ctfr_pkg::TYPE_SF, 4'd7}));
	endtask

	task automatic test_single_frames;
		frame_t f;
		send_frame(rand_payload(ctfr_pkg::ID_LOW, {ctfr_pkg::TYPE_SF, 4'd0}));
		f = rand_payload(ctfr_pkg::ID_HIGH, 8'h00);
		f.b = {8{8'hFF}};
		f.b[0] = {ctfr_pkg::TYPE_SF, 4'd7};
		send_frame(f);
		f.b = '0;
		f.b[0] = {ctfr_pkg::TYPE_SF, 4'hF};
		send_frame(f);
	endtask

	task automatic test_first_frame_lengths;
		send_frame(first_frame(ctfr_pkg::ID_LOW, ctfr_pkg::FF_HEAD_BYTES - 1));
		send_frame(first_frame(ctfr_pkg::ID_LOW, ctfr_pkg::MAX_MESSAGE + 1));
		send_frame(first_frame(ctfr_pkg::ID_HIGH, 4095));
		send_message(ctfr_pkg::ID_LOW + 11'd1, ctfr_pkg::FF_HEAD_BYTES, 0, 0);
		send_message(ctfr_pkg::ID_HIGH, ctfr_pkg::MAX_MESSAGE, 0, 0);
	endtask

	task automatic test_sequence_errors;
		send_frame(rand_payload(ctfr_pkg::ID_LOW, {ctfr_pkg::TYPE_CF, 4'd1}));
		send_frame(first_frame(ctfr_pkg::ID_LOW + 11'd2, 20));
		send_frame(rand_payload(ctfr_pkg::ID_LOW + 11'd2, {ctfr_pkg::TYPE_CF, 4'd2}));
		// a new first frame discards the one in progress
		send_frame(first_frame(ctfr_pkg::ID_LOW + 11'd4, 13));
		send_frame(first_frame(ctfr_pkg::ID_LOW + 11'd5, 8));
		send_frame(rand_payload(ctfr_pkg::ID_LOW + 11'd6, {ctfr_pkg::TYPE_CF, 4'd1}));
	endtask

	task automatic test_ignored_types;
		send_frame(first_frame(ctfr_pkg::ID_HIGH, 10));
		send_frame(rand_payload(ctfr_pkg::ID_HIGH, {TYPE_FC, 4'd0}));
		send_frame(rand_payload(ctfr_pkg::ID_HIGH, 8'hFF));
		send_frame(rand_payload(ctfr_pkg::ID_HIGH, {ctfr_pkg::TYPE_CF, 4'd1}));
	endtask

	task automatic test_random_traffic(input int n_items, input int tx_idle, input int rx_idle);
		int start;
		int pick;
		send_idle_pct = tx_idle;
		recv_idle_pct = rx_idle;
		start = frames_sent;
		while (frames_sent - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_message(rand_id(),
					$urandom_range(ctfr_pkg::FF_HEAD_BYTES, ctfr_pkg::MAX_MESSAGE), 10, 8);
			end else if (pick < 75) begin
				send_frame(rand_payload(rand_id(), {ctfr_pkg::TYPE_SF, 4'($urandom())}));
			end else if (pick < 85) begin
				send_frame(first_frame(rand_id(), $urandom_range(0, 4095)));
			end else if (pick < 93) begin
				send_frame(rand_payload(rand_id(), {ctfr_pkg::TYPE_CF, 4'($urandom())}));
			end else begin
				send_frame(noise_frame());
			end
		end
	endtask

	// output held off while a full message and a burst of single frames go in
	task automatic test_backpressure;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_token <= hold_token + 1;
		send_message(ctfr_pkg::ID_LOW + 11'd3, ctfr_pkg::MAX_MESSAGE, 0, 0);
		repeat (6) begin
			send_frame(rand_payload(rand_id(), {ctfr_pkg::TYPE_SF, 4'd7}));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		can_id = '0;
		data0 = '0;
		data1 = '0;
		data2 = '0;
		data3 = '0;
		data4 = '0;
		data5 = '0;
		data6 = '0;
		data7 = '0;
		send_idle_pct = 24;
		recv_idle_pct = 88;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_foreign_ids();
		test_single_frames();
		test_first_frame_lengths();
		test_sequence_errors();
		test_ignored_types();
		test_random_traffic(115, 24, 88);
		test_random_traffic(115, 88, 24);
		test_random_traffic(115, 0, 0);
		test_backpressure();

		in_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ctfr_pkg.sv
rtl/ctfr_front.sv
rtl/ctfr_fifo.sv
rtl/ctfr_back.sv
rtl/can_transport_frame_reassembler.sv
dv/tb_can_transport_frame_reassembler.sv
